FILE: rtl/core/smng_pkg.sv
// Package for the stereo noise generator: widths, codes, filter constants and helpers.
package smng_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int FRAC_BITS    = 28;
	localparam int ACC_WIDTH    = SAMPLE_WIDTH + 4;
	localparam int PROD_WIDTH   = ACC_WIDTH + SAMPLE_WIDTH;
	localparam int SEED_WIDTH   = 17;
	localparam int MODE_WIDTH   = 3;
	localparam int ADDR_WIDTH   = 5;
	localparam int SEED_MAX     = 99999;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HASH,
		ST_WHITE,
		ST_GAUSS,
		ST_MEAN,
		ST_BROWN1,
		ST_BROWN2,
		ST_PINKA,
		ST_PINKB,
		ST_PSUM,
		ST_PGAIN,
		ST_P6,
		ST_CRACK,
		ST_LEVEL,
		ST_DONE
	} state_t;

	localparam logic [MODE_WIDTH-1:0] MODE_WHITE = 3'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_GAUSS = 3'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_BROWN = 3'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_PINK  = 3'd3;

	localparam logic [2:0] REG_SEED  = 3'd0;
	localparam logic [2:0] REG_MODE  = 3'd1;
	localparam logic [2:0] REG_MEAN  = 3'd2;
	localparam logic [2:0] REG_DEV   = 3'd3;
	localparam logic [2:0] REG_LEVEL = 3'd4;

	localparam logic [31:0] HASH_GOLDEN = 32'h9e3779b9;
	localparam logic [31:0] HASH_MUL    = 32'h045d9f3b;
	localparam logic [31:0] LCG_MUL     = 32'd1664525;
	localparam logic [31:0] LCG_ADD     = 32'd1013904223;

	// constant held at 2^32 brought to FRAC_BITS, rounded half up
	function automatic logic signed [SAMPLE_WIDTH-1:0] scale_k(input logic [32:0] k);
		logic [32:0] t;
		t = k + (33'd1 << (31 - FRAC_BITS));
		return SAMPLE_WIDTH'(t >> (32 - FRAC_BITS));
	endfunction

	localparam logic signed [SAMPLE_WIDTH-1:0] C_PA [6] = '{
		scale_k(33'd4290071033), scale_k(33'd4266276914), scale_k(33'd4161823310),
		scale_k(33'd3721589162), scale_k(33'd2362232013), scale_k(33'd3271047093)
	};
	localparam logic signed [SAMPLE_WIDTH-1:0] C_PB [6] = '{
		scale_k(33'd238447565), scale_k(33'd322448535), scale_k(33'd660789308),
		scale_k(33'd1333525498), scale_k(33'd2289012269), scale_k(33'd72576357)
	};
	localparam logic signed [SAMPLE_WIDTH-1:0] C_WSUM  = scale_k(33'd2302961464);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_GAIN  = scale_k(33'd472446403);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_P6    = scale_k(33'd497898379);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_CRK   = scale_k(33'd4037269258);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_BRN   = scale_k(33'd214748365);
	localparam logic signed [SAMPLE_WIDTH-1:0] C_MILLI = scale_k(33'd4294967);

	localparam logic signed [ACC_WIDTH-1:0] ONE_Q = ACC_WIDTH'(longint'(1) << FRAC_BITS);
	localparam logic signed [ACC_WIDTH-1:0] SIX_Q = ACC_WIDTH'(longint'(6) << FRAC_BITS);
	localparam logic signed [ACC_WIDTH-1:0] SMAX_A =
		ACC_WIDTH'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ACC_WIDTH-1:0] SMIN_A = -SMAX_A - ACC_WIDTH'(1);

	function automatic logic signed [ACC_WIDTH-1:0] clamp_one(
		input logic signed [ACC_WIDTH-1:0] x);
		if (x > ONE_Q)
			return ONE_Q;
		else if (x < -ONE_Q)
			return -ONE_Q;
		return x;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_s(
		input logic signed [ACC_WIDTH-1:0] x);
		if (x > SMAX_A)
			return SAMPLE_WIDTH'(SMAX_A);
		else if (x < SMIN_A)
			return SAMPLE_WIDTH'(SMIN_A);
		return SAMPLE_WIDTH'(x);
	endfunction

endpackage

FILE: rtl/core/stereo_multimode_noise_generator_unit.sv
// Top level of the stereo noise generator: config registers, sequencer and shared multiplier.
// Each multiply goes through the one shared multiplier, whose product is registered; channels are
// worked out in turn (white, gaussian, brown, pink or crackle), after a reseed where one is due.
// A new tick is taken only in idle, once the result pair has been loaded into the output register.
// A tick that is low is taken and gives no result.
// Reset clears config to its defaults, generator and filter state to zero; first high tick reseeds.
module stereo_multimode_noise_generator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [smng_pkg::ADDR_WIDTH-1:0]      paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 tick_valid,
	output logic                                 tick_ready,
	input  logic                                 tick,
	output logic                                 sample_valid,
	input  logic                                 sample_ready,
	output logic signed [smng_pkg::SAMPLE_WIDTH-1:0] left_sample,
	output logic signed [smng_pkg::SAMPLE_WIDTH-1:0] right_sample
);

	localparam int SW = smng_pkg::SAMPLE_WIDTH;
	localparam int FB = smng_pkg::FRAC_BITS;
	localparam int AW = smng_pkg::ACC_WIDTH;
	localparam int PW = smng_pkg::PROD_WIDTH;

	logic [smng_pkg::SEED_WIDTH-1:0] seed_q, applied_seed_q, seed_sat;
	logic [smng_pkg::MODE_WIDTH-1:0] mode_q;
	logic signed [SW-1:0]            mean_q, level_q;
	logic [SW-2:0]                   dev_q;

	logic [31:0]             lcg_q [2];
	logic signed [FB+1:0]    brown_q [2];
	logic signed [SW-1:0]    pink_q [14];
	logic                    seed_ok_q;

	smng_pkg::state_t state_q, state_d;
	logic                 phase_q, chan_q, mul_st;
	logic [3:0]           cnt_q, pink_idx;
	logic [31:0]          h_q, mix, lcg_new, hh, hf;
	logic signed [FB+1:0] white_q;
	logic signed [AW-1:0] acc_q, sum_q;
	logic signed [SW-1:0] res_l_q, res_r_q, left_q, right_q;
	logic                 out_valid_q;

	logic                 cfg_wr, accept, reseed, crack;
	logic [2:0]           cfg_idx;
	logic signed [AW-1:0] opa, mean_ext, dev_ext, white_ext, dmin, mres_ext, aw_abs;
	logic signed [AW-1:0] bsum, pin, white_full, gsum, crk_v;
	logic signed [SW-1:0] opb, mres, pink_rd, pnew;
	logic [AW-1:0]        ua;
	logic [SW-1:0]        ub;
	logic [PW-1:0]        prod_s1;
	logic                 neg_s1;
	logic [PW:0]          rnd, rsh;
	logic [SW:0]          lim, mag;
	logic [32:0]          wtmp, utmp;

	// config port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[smng_pkg::ADDR_WIDTH-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		case (cfg_idx)
			smng_pkg::REG_SEED:  prdata = 32'(seed_q);
			smng_pkg::REG_MODE:  prdata = 32'(mode_q);
			smng_pkg::REG_MEAN:  prdata = 32'(mean_q);
			smng_pkg::REG_DEV:   prdata = 32'({1'b0, dev_q});
			smng_pkg::REG_LEVEL: prdata = 32'(level_q);
			default:             prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			mode_q  <= smng_pkg::MODE_WHITE;
			mean_q  <= '0;
			dev_q   <= (SW-1)'(smng_pkg::ONE_Q);
			level_q <= SW'(smng_pkg::ONE_Q);
		end else if (cfg_wr) begin
			case (cfg_idx)
				smng_pkg::REG_SEED:  seed_q  <= pwdata[smng_pkg::SEED_WIDTH-1:0];
				smng_pkg::REG_MODE:  mode_q  <= pwdata[smng_pkg::MODE_WIDTH-1:0];
				smng_pkg::REG_MEAN:  mean_q  <= $signed(pwdata[SW-1:0]);
				smng_pkg::REG_DEV:   dev_q   <= pwdata[SW-2:0];
				smng_pkg::REG_LEVEL: level_q <= $signed(pwdata[SW-1:0]);
				default: ;
			endcase
		end
	end

	// handshake
	assign tick_ready   = (state_q == smng_pkg::ST_IDLE);
	assign accept       = tick_valid & tick_ready;
	assign sample_valid = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;

	assign seed_sat = (seed_q > smng_pkg::SEED_WIDTH'(smng_pkg::SEED_MAX)) ?
		smng_pkg::SEED_WIDTH'(smng_pkg::SEED_MAX) : seed_q;
	assign reseed   = !seed_ok_q || (seed_sat != applied_seed_q);

	// operand preparation
	assign mix       = h_q ^ (h_q >> 16);
	assign mean_ext  = AW'(mean_q);
	assign dev_ext   = $signed({{(AW-SW+1){1'b0}}, dev_q});
	assign white_ext = AW'(white_q);
	assign dmin      = (dev_ext < AW'(smng_pkg::C_MILLI)) ? AW'(smng_pkg::C_MILLI) : dev_ext;
	assign pink_idx  = (chan_q ? 4'd7 : 4'd0) +
		(((state_q == smng_pkg::ST_WHITE) || (state_q == smng_pkg::ST_P6)) ? 4'd6 : cnt_q);
	assign pink_rd   = pink_q[pink_idx];

	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			smng_pkg::ST_HASH: begin
				opa = $signed({{(AW-32){1'b0}}, mix});
				opb = $signed(SW'(smng_pkg::HASH_MUL));
			end
			smng_pkg::ST_WHITE, smng_pkg::ST_GAUSS: begin
				opa = $signed({{(AW-32){1'b0}}, lcg_q[chan_q]});
				opb = $signed(SW'(smng_pkg::LCG_MUL));
			end
			smng_pkg::ST_MEAN: begin
				opa = (mode_q == smng_pkg::MODE_GAUSS) ? acc_q - smng_pkg::SIX_Q : white_ext;
				opb = $signed({1'b0, dev_q});
			end
			smng_pkg::ST_BROWN1: begin
				opa = white_ext;
				opb = dmin[SW-1:0];
			end
			smng_pkg::ST_BROWN2: begin
				opa = acc_q;
				opb = smng_pkg::C_BRN;
			end
			smng_pkg::ST_PINKA: begin
				opa = AW'(pink_rd);
				opb = smng_pkg::C_PA[cnt_q[2:0]];
			end
			smng_pkg::ST_PINKB: begin
				opa = white_ext;
				opb = smng_pkg::C_PB[cnt_q[2:0]];
			end
			smng_pkg::ST_PSUM: begin
				opa = white_ext;
				opb = smng_pkg::C_WSUM;
			end
			smng_pkg::ST_PGAIN: begin
				opa = sum_q;
				opb = smng_pkg::C_GAIN;
			end
			smng_pkg::ST_P6: begin
				opa = white_ext;
				opb = smng_pkg::C_P6;
			end
			smng_pkg::ST_LEVEL: begin
				opa = acc_q;
				opb = level_q;
			end
			default: ;
		endcase
	end

	// shared sign-magnitude multiplier
	assign ua = opa[AW-1] ? AW'(-opa) : AW'(opa);
	assign ub = opb[SW-1] ? SW'(-opb) : SW'(opb);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(ua) * PW'(ub);
		neg_s1  <= opa[AW-1] ^ opb[SW-1];
	end

	// round half away from zero and saturate
	assign rnd      = {1'b0, prod_s1} + ((PW+1)'(1) << (FB - 1));
	assign rsh      = rnd >> FB;
	assign lim      = neg_s1 ? ((SW+1)'(1) << (SW - 1)) : (((SW+1)'(1) << (SW - 1)) - 1'b1);
	assign mag      = (rsh > (PW+1)'(lim)) ? lim : rsh[SW:0];
	assign mres     = neg_s1 ? $signed(SW'(-mag)) : $signed(SW'(mag));
	assign mres_ext = AW'(mres);

	assign lcg_new    = prod_s1[31:0] + smng_pkg::LCG_ADD;
	assign wtmp       = ({1'b0, lcg_new} + 33'd4) >> (32 - FB - 1);
	assign white_full = $signed({{(AW-FB-2){1'b0}}, wtmp[FB+1:0]}) - smng_pkg::ONE_Q;
	assign utmp       = ({1'b0, lcg_new} + 33'd8) >> (32 - FB);
	assign gsum       = acc_q + $signed({{(AW-FB-2){1'b0}}, utmp[FB+1:0]});
	assign hh         = prod_s1[31:0];
	assign hf         = ((hh ^ (hh >> 16)) == 32'd0) ? 32'd1 : (hh ^ (hh >> 16));

	assign bsum   = smng_pkg::clamp_one(AW'(brown_q[chan_q]) + mres_ext);
	assign pin    = (cnt_q == 4'd5) ? acc_q - mres_ext : acc_q + mres_ext;
	assign pnew   = smng_pkg::sat_s(pin);
	assign aw_abs = white_ext[AW-1] ? -white_ext : white_ext;
	assign crack  = aw_abs > AW'(smng_pkg::C_CRK);
	assign crk_v  = crack ? (white_ext[AW-1] ? -dev_ext : dev_ext) : '0;

	// sequencer
	assign mul_st = (state_q != smng_pkg::ST_IDLE) && (state_q != smng_pkg::ST_CRACK) &&
		(state_q != smng_pkg::ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= smng_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		if (!(mul_st && !phase_q)) begin
			case (state_q)
				smng_pkg::ST_IDLE:
					if (accept && tick)
						state_d = reseed ? smng_pkg::ST_HASH : smng_pkg::ST_WHITE;
				smng_pkg::ST_HASH:
					if (cnt_q == 4'd1 && chan_q)
						state_d = smng_pkg::ST_WHITE;
				smng_pkg::ST_WHITE: begin
					case (mode_q)
						smng_pkg::MODE_WHITE: state_d = smng_pkg::ST_MEAN;
						smng_pkg::MODE_GAUSS: state_d = smng_pkg::ST_GAUSS;
						smng_pkg::MODE_BROWN: state_d = smng_pkg::ST_BROWN1;
						smng_pkg::MODE_PINK:  state_d = smng_pkg::ST_PINKA;
						default:              state_d = smng_pkg::ST_CRACK;
					endcase
				end
				smng_pkg::ST_GAUSS:
					if (cnt_q == 4'd11)
						state_d = smng_pkg::ST_MEAN;
				smng_pkg::ST_MEAN:   state_d = smng_pkg::ST_LEVEL;
				smng_pkg::ST_BROWN1: state_d = smng_pkg::ST_BROWN2;
				smng_pkg::ST_BROWN2: state_d = smng_pkg::ST_LEVEL;
				smng_pkg::ST_PINKA:  state_d = smng_pkg::ST_PINKB;
				smng_pkg::ST_PINKB:
					state_d = (cnt_q == 4'd5) ? smng_pkg::ST_PSUM : smng_pkg::ST_PINKA;
				smng_pkg::ST_PSUM:   state_d = smng_pkg::ST_PGAIN;
				smng_pkg::ST_PGAIN:  state_d = smng_pkg::ST_P6;
				smng_pkg::ST_P6:     state_d = smng_pkg::ST_LEVEL;
				smng_pkg::ST_CRACK:  state_d = smng_pkg::ST_LEVEL;
				smng_pkg::ST_LEVEL:
					state_d = chan_q ? smng_pkg::ST_DONE : smng_pkg::ST_WHITE;
				smng_pkg::ST_DONE:
					if (!out_valid_q || sample_ready)
						state_d = smng_pkg::ST_IDLE;
				default: state_d = smng_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= 1'b0;
			chan_q         <= 1'b0;
			cnt_q          <= '0;
			seed_ok_q      <= 1'b0;
			applied_seed_q <= '0;
			lcg_q[0]       <= '0;
			lcg_q[1]       <= '0;
			brown_q[0]     <= '0;
			brown_q[1]     <= '0;
			for (int i = 0; i < 14; i++)
				pink_q[i] <= '0;
			out_valid_q    <= 1'b0;
			h_q            <= '0;
			white_q        <= '0;
			acc_q          <= '0;
			sum_q          <= '0;
			res_l_q        <= '0;
			res_r_q        <= '0;
			left_q         <= '0;
			right_q        <= '0;
		end else begin
			phase_q <= mul_st ? ~phase_q : 1'b0;
			if (sample_valid && sample_ready && (state_q != smng_pkg::ST_DONE))
				out_valid_q <= 1'b0;
			case (state_q)
				smng_pkg::ST_IDLE:
					if (accept && tick) begin
						chan_q <= 1'b0;
						cnt_q  <= '0;
						if (reseed) begin
							applied_seed_q <= seed_sat;
							seed_ok_q      <= 1'b1;
							h_q            <= 32'(seed_sat);
							brown_q[0]     <= '0;
							brown_q[1]     <= '0;
							for (int i = 0; i < 14; i++)
								pink_q[i] <= '0;
						end
					end
				smng_pkg::ST_HASH:
					if (phase_q) begin
						if (cnt_q == 4'd0) begin
							h_q   <= hh;
							cnt_q <= 4'd1;
						end else begin
							lcg_q[chan_q] <= hf;
							cnt_q         <= '0;
							chan_q        <= ~chan_q;
							h_q           <= 32'(applied_seed_q) ^ smng_pkg::HASH_GOLDEN;
						end
					end
				smng_pkg::ST_WHITE:
					if (phase_q) begin
						lcg_q[chan_q] <= lcg_new;
						white_q       <= white_full[FB+1:0];
						cnt_q         <= '0;
						acc_q         <= '0;
						sum_q         <= AW'(pink_rd);
					end
				smng_pkg::ST_GAUSS:
					if (phase_q) begin
						lcg_q[chan_q] <= lcg_new;
						acc_q         <= gsum;
						cnt_q         <= cnt_q + 4'd1;
					end
				smng_pkg::ST_MEAN, smng_pkg::ST_PGAIN:
					if (phase_q)
						acc_q <= smng_pkg::clamp_one(mean_ext + mres_ext);
				smng_pkg::ST_BROWN1:
					if (phase_q)
						acc_q <= mres_ext;
				smng_pkg::ST_BROWN2:
					if (phase_q) begin
						brown_q[chan_q] <= bsum[FB+1:0];
						acc_q           <= smng_pkg::clamp_one(mean_ext + bsum);
					end
				smng_pkg::ST_PINKA:
					if (phase_q)
						acc_q <= (cnt_q == 4'd5) ? -mres_ext : mres_ext;
				smng_pkg::ST_PINKB:
					if (phase_q) begin
						pink_q[pink_idx] <= pnew;
						sum_q            <= sum_q + AW'(pnew);
						cnt_q            <= cnt_q + 4'd1;
					end
				smng_pkg::ST_PSUM:
					if (phase_q)
						sum_q <= sum_q + mres_ext;
				smng_pkg::ST_P6:
					if (phase_q)
						pink_q[pink_idx] <= mres;
				smng_pkg::ST_CRACK:
					acc_q <= smng_pkg::clamp_one(mean_ext + crk_v);
				smng_pkg::ST_LEVEL:
					if (phase_q) begin
						if (chan_q)
							res_r_q <= mres;
						else
							res_l_q <= mres;
						chan_q <= 1'b1;
					end
				smng_pkg::ST_DONE:
					if (!out_valid_q || sample_ready) begin
						out_valid_q <= 1'b1;
						left_q      <= res_l_q;
						right_q     <= res_r_q;
					end
				default: ;
			endcase
		end
	end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the stereo noise generator: APB set-up, tick stream, sample checks.
`timescale 1ns / 100ps
module tb_top;

	localparam longint Q_ONE = 64'sd1 << 28;

	typedef struct {
		logic [31:0] l;
		logic [31:0] r;
	} sample_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [smng_pkg::ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        tick_valid = 1'b0, tick = 1'b0, tick_ready;
	logic        sample_valid, sample_ready = 1'b0;
	logic signed [31:0] left_sample, right_sample;

	stereo_multimode_noise_generator_unit dut (.*);

	always #6 clk = ~clk;

	// shadow registers
	logic [16:0] sh_seed  = '0;
	logic [2:0]  sh_mode  = smng_pkg::MODE_WHITE;
	logic [31:0] sh_mean  = '0;
	logic [30:0] sh_dev   = 31'h1000_0000;
	logic [31:0] sh_level = 32'h1000_0000;

	// generator state
	logic [31:0] gen_lcg [2];
	longint      brown_lvl [2];
	longint      pink_tap [14];
	logic [16:0] seed_now;
	bit          seed_ok;

	bit           tick_q [$];
	sample_pair_t expected_pairs [$];
	int           errors = 0, samples_seen = 0, ticks_taken = 0;
	bit           tick_fire = 1'b0;
	int           tx_gap = 0, rx_gap = 0, hold_cnt = 0;
	bit           hold_req = 1'b0;

	function automatic longint kq(longint k);
		return (k + 8) >>> 4;
	endfunction

	function automatic longint qmul(longint a, longint b);
		bit          neg;
		logic [127:0] ua, ub, p;
		longint      lim;
		neg = (a < 0) != (b < 0);
		ua = 128'(a < 0 ? -a : a);
		ub = 128'(b < 0 ? -b : b);
		p = ((ua * ub) + (128'd1 << 27)) >> 28;
		lim = neg ? (64'sd1 <<< 31) : (64'sd1 <<< 31) - 1;
		if (p > 128'(lim))
			p = 128'(lim);
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint qsat(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint clamp1(longint x);
		return x > Q_ONE ? Q_ONE : (x < -Q_ONE ? -Q_ONE : x);
	endfunction

	function automatic logic [31:0] hash32(logic [31:0] h);
		h = h ^ (h >> 16);
		h = h * smng_pkg::HASH_MUL;
		h = h ^ (h >> 16);
		h = h * smng_pkg::HASH_MUL;
		h = h ^ (h >> 16);
		return h == 0 ? 32'd1 : h;
	endfunction

	function automatic longint lcg_next(int c);
		gen_lcg[c] = gen_lcg[c] * smng_pkg::LCG_MUL + smng_pkg::LCG_ADD;
		return longint'(gen_lcg[c]);
	endfunction

	function automatic longint channel_noise(int c, logic [2:0] mode, longint mean, longint dev);
		longint white, g, d, b, s, o;
		longint pa [6], pb [6];
		int base;
		pa = '{64'd4290071033, 64'd4266276914, 64'd4161823310, 64'd3721589162,
			64'd2362232013, 64'd3271047093};
		pb = '{64'd238447565, 64'd322448535, 64'd660789308, 64'd1333525498,
			64'd2289012269, 64'd72576357};
		base = c * 7;
		white = ((lcg_next(c) + 4) >>> 3) - Q_ONE;
		case (mode)
			smng_pkg::MODE_GAUSS: begin
				g = 0;
				for (int i = 0; i < 12; i++)
					g += (lcg_next(c) + 8) >>> 4;
				g -= 6 * Q_ONE;
				return mean + qmul(g, dev);
			end
			smng_pkg::MODE_BROWN: begin
				d = dev < kq(4294967) ? kq(4294967) : dev;
				b = clamp1(brown_lvl[c] + qmul(qmul(white, d), kq(214748365)));
				brown_lvl[c] = b;
				return mean + b;
			end
			smng_pkg::MODE_PINK: begin
				for (int i = 0; i < 5; i++)
					pink_tap[base+i] = qsat(qmul(kq(pa[i]), pink_tap[base+i])
						+ qmul(white, kq(pb[i])));
				pink_tap[base+5] = qsat(-qmul(kq(pa[5]), pink_tap[base+5])
					- qmul(white, kq(pb[5])));
				s = qmul(white, kq(64'd2302961464));
				for (int i = 0; i < 7; i++)
					s += pink_tap[base+i];
				o = mean + qmul(s, kq(472446403));
				pink_tap[base+6] = qmul(white, kq(497898379));
				return o;
			end
			smng_pkg::MODE_WHITE:
				return mean + qmul(white, dev);
			default: begin
				if ((white < 0 ? -white : white) > kq(64'd4037269258))
					return mean + (white > 0 ? dev : -dev);
				return mean;
			end
		endcase
	endfunction

	function automatic sample_pair_t predict_pair();
		logic [16:0]  sd;
		longint       mean, dev, lvl, v;
		sample_pair_t p;
		sd = sh_seed > smng_pkg::SEED_MAX ? 17'(smng_pkg::SEED_MAX) : sh_seed;
		if (!seed_ok || sd != seed_now) begin
			seed_now = sd;
			seed_ok = 1'b1;
			gen_lcg[0] = hash32(32'(sd));
			gen_lcg[1] = hash32(32'(sd) ^ smng_pkg::HASH_GOLDEN);
			brown_lvl[0] = 0;
			brown_lvl[1] = 0;
			for (int i = 0; i < 14; i++)
				pink_tap[i] = 0;
		end
		mean = longint'($signed(sh_mean));
		dev = longint'(sh_dev);
		lvl = longint'($signed(sh_level));
		v = clamp1(channel_noise(0, sh_mode, mean, dev));
		p.l = 32'(qmul(v, lvl));
		v = clamp1(channel_noise(1, sh_mode, mean, dev));
		p.r = 32'(qmul(v, lvl));
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s at %0t: got %h want %h", what, $time, got, want);
		errors++;
	endtask

	// tick driver
	always @(negedge clk) begin
		if (!tick_valid || tick_fire) begin
			if (tx_gap > 0) begin
				tx_gap--;
				tick_valid <= 1'b0;
			end else if (tick_q.size() > 0) begin
				tick <= tick_q.pop_front();
				tick_valid <= 1'b1;
				tx_gap = pick_gap();
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	// sample receiver
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 3000;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			sample_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			sample_ready <= 1'b0;
		end else begin
			sample_ready <= 1'b1;
			rx_gap = pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		sample_pair_t e;
		tick_fire <= tick_valid && tick_ready;
		if (arst_n && tick_valid && tick_ready) begin
			ticks_taken++;
			if (tick)
				expected_pairs.push_back(predict_pair());
		end
		if (arst_n && sample_valid && sample_ready) begin
			samples_seen++;
			if (expected_pairs.size() == 0) begin
				report_mismatch("unexpected sample", left_sample, 32'd0);
			end else begin
				e = expected_pairs.pop_front();
				if (left_sample !== e.l)
					report_mismatch("left", left_sample, e.l);
				if (right_sample !== e.r)
					report_mismatch("right", right_sample, e.r);
			end
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = smng_pkg::ADDR_WIDTH'({idx, 2'b00});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		case (idx)
			smng_pkg::REG_SEED:  sh_seed = val[16:0];
			smng_pkg::REG_MODE:  sh_mode = val[2:0];
			smng_pkg::REG_MEAN:  sh_mean = val;
			smng_pkg::REG_DEV:   sh_dev = val[30:0];
			smng_pkg::REG_LEVEL: sh_level = val;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic wait_idle();
		while (tick_q.size() > 0 || tick_valid || expected_pairs.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic run_ticks(int n, int low_pct);
		for (int i = 0; i < n; i++)
			tick_q.push_back($urandom_range(0, 99) >= low_pct);
		wait_idle();
	endtask

	function automatic logic [31:0] rand_fixed();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'($signed(32'($urandom_range(0, 32'h3000_0000))) - 32'sh1800_0000);
	endfunction

	initial begin
		seed_ok = 1'b0;
		seed_now = '0;
		gen_lcg = '{32'd0, 32'd0};
		brown_lvl = '{0, 0};
		for (int i = 0; i < 14; i++)
			pink_tap[i] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults, with a low tick between two high ones
		tick_q = '{1'b1, 1'b0, 1'b1};
		wait_idle();
		for (int m = 0; m < 8; m++) begin
			apb_write(smng_pkg::REG_MODE, 32'(m));
			run_ticks(2, 0);
		end
		apb_write(smng_pkg::REG_MODE, 32'(smng_pkg::MODE_WHITE));
		apb_write(smng_pkg::REG_MEAN, 32'h7fff_ffff);
		apb_write(smng_pkg::REG_LEVEL, 32'h8000_0000);
		apb_write(smng_pkg::REG_DEV, 32'h0);
		run_ticks(2, 0);
		apb_write(smng_pkg::REG_MEAN, 32'h8000_0000);
		apb_write(smng_pkg::REG_DEV, 32'h7fff_ffff);
		apb_write(smng_pkg::REG_LEVEL, 32'h7fff_ffff);
		apb_write(smng_pkg::REG_SEED, 32'd131071);
		run_ticks(2, 0);
		apb_write(smng_pkg::REG_SEED, 32'd99999);
		apb_write(3'd7, 32'hffff_ffff);
		run_ticks(2, 0);
		apb_write(smng_pkg::REG_SEED, 32'd0);
		apb_write(smng_pkg::REG_MEAN, 32'd0);
		apb_write(smng_pkg::REG_MODE, 32'(smng_pkg::MODE_BROWN));
		apb_write(smng_pkg::REG_DEV, 32'h0);
		run_ticks(2, 0);

		for (int ph = 0; ph < 20; ph++) begin
			if ($urandom_range(0, 2) != 0)
				apb_write(smng_pkg::REG_SEED,
					$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 99999));
			apb_write(smng_pkg::REG_MODE, $urandom_range(0, 7));
			apb_write(smng_pkg::REG_MEAN, $urandom_range(0, 2) == 0 ? rand_fixed() : 32'd0);
			apb_write(smng_pkg::REG_DEV,
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h2000_0000));
			apb_write(smng_pkg::REG_LEVEL, rand_fixed());
			if (ph == 5)
				hold_req = 1'b1;
			run_ticks($urandom_range(40, 100), 8);
		end
		wait_idle();

		$display("covered %0d tick transfers and %0d sample transfers across all modes,",
			ticks_taken, samples_seen);
		$display("register extremes, seed saturation and reseeds, with a long receiver stall");
		if (errors == 0)
			$display("PASS stereo_multimode_noise_generator_unit");
		else
			$display("FAIL stereo_multimode_noise_generator_unit");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAIL stereo_multimode_noise_generator_unit");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/smng_pkg.sv
rtl/core/stereo_multimode_noise_generator_unit.sv
bench/tb_top.sv
